### rtl/core/abdb_pkg.sv
// ----------------------------------------------------------------------------
// abdb_pkg
// Shared types and constants for the area box downscaler.
// ----------------------------------------------------------------------------
package abdb_pkg;

  localparam int PIX_W      = 8;
  localparam int COMP_N     = 4;
  localparam int ACC_W      = 24;
  localparam int OUT_COL_W  = 6;
  localparam int OUT_ROW_W  = 8;
  localparam int DIV_STEPS  = 8;

  localparam int REG_SW_W   = 9;
  localparam int REG_SH_W   = 9;
  localparam int REG_DW_W   = 7;
  localparam int REG_DH_W   = 9;

  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;

  localparam int MAX_SRC_W_DEF = 256;
  localparam int MAX_SRC_H_DEF = 256;
  localparam int MAX_OUT_W_DEF = 64;

  // register indexes (byte address / 4)
  localparam logic [2:0] REG_SRC_WIDTH  = 3'd0;
  localparam logic [2:0] REG_SRC_HEIGHT = 3'd1;
  localparam logic [2:0] REG_DEST_WIDTH = 3'd2;
  localparam logic [2:0] REG_DEST_HEIGHT = 3'd3;
  localparam logic [2:0] REG_RGBA_MODE  = 3'd4;

  localparam logic [1:0] PART_LAST = 2'd3;

  typedef struct packed {
    logic       accept;
    logic       rd;
    logic       wr;
    logic       col_adv;
    logic       em_rd;
    logic       em_ld;
    logic       em_div;
    logic       em_out;
    logic       row_adv;
    logic [1:0] part;
    logic [2:0] iter;
  } abdb_cmd_t;

  typedef struct packed {
    logic w_zero;
    logic row_end;
    logic emit;
    logic last_k;
    logic out_free;
  } abdb_stat_t;

endpackage

### rtl/core/area_box_downscale_bitmap.sv
// ----------------------------------------------------------------------------
// area_box_downscale_bitmap
// Area-averaging bitmap downscaler with APB configuration.
// ----------------------------------------------------------------------------
// Source pixels enter in raster order, one item per pixel (gray in comp0, or
// premultiplied RGBA in comp0..comp3). Each pixel is accepted, then each of the
// four candidate accumulator cells is either skipped or updated by a read and a
// write (it overlaps one to four cells), then the column advances, at a pace
// set by the single read-modify-write port of the accumulator memory. At the
// end of a source row that completes an output row, the block emits out_w
// items, each through a memory read, a load and an 8-step restoring divider,
// plus any wait on out_ready, and then advances the row.
// The next pixel is accepted while the last result still sits in the output
// register. Accumulators clear through valid bits, so there is no clearing
// pass; a config write restarts the frame and blocks input while restart is high.
// ----------------------------------------------------------------------------
module area_box_downscale_bitmap #(
  parameter int MAX_SRC_W = abdb_pkg::MAX_SRC_W_DEF,
  parameter int MAX_SRC_H = abdb_pkg::MAX_SRC_H_DEF,
  parameter int MAX_OUT_W = abdb_pkg::MAX_OUT_W_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [abdb_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [abdb_pkg::APB_DATA_W-1:0] pwdata,
  output logic [abdb_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [abdb_pkg::PIX_W-1:0]      comp0,
  input  logic [abdb_pkg::PIX_W-1:0]      comp1,
  input  logic [abdb_pkg::PIX_W-1:0]      comp2,
  input  logic [abdb_pkg::PIX_W-1:0]      comp3,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [abdb_pkg::PIX_W-1:0]      out0,
  output logic [abdb_pkg::PIX_W-1:0]      out1,
  output logic [abdb_pkg::PIX_W-1:0]      out2,
  output logic [abdb_pkg::PIX_W-1:0]      out3,
  output logic [abdb_pkg::OUT_COL_W-1:0]  out_col,
  output logic [abdb_pkg::OUT_ROW_W-1:0]  out_row,
  output logic                            row_last,
  output logic                            frame_last
);
  import abdb_pkg::*;

  localparam int CW  = $clog2(MAX_SRC_W + 1);
  localparam int HW  = $clog2(MAX_SRC_H + 1);
  localparam int OWW = $clog2(MAX_OUT_W + 1);
  localparam int CIW = (MAX_OUT_W > 1) ? $clog2(MAX_OUT_W) : 1;

  // configuration registers
  logic [REG_SW_W-1:0] src_width;
  logic [REG_SH_W-1:0] src_height;
  logic [REG_DW_W-1:0] dest_width;
  logic [REG_DH_W-1:0] dest_height;
  logic                rgba_mode;
  logic                restart;
  logic                wr_en;
  logic [2:0]          reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      src_width   <= REG_SW_W'(1);
      src_height  <= REG_SH_W'(1);
      dest_width  <= REG_DW_W'(1);
      dest_height <= REG_DH_W'(1);
      rgba_mode   <= 1'b0;
      restart     <= 1'b1;  // load the frame state from the reset sizes
    end else begin
      restart <= 1'b0;
      if (wr_en) begin
        case (reg_idx)
          REG_SRC_WIDTH: begin
            src_width <= pwdata[REG_SW_W-1:0];
            restart   <= 1'b1;
          end
          REG_SRC_HEIGHT: begin
            src_height <= pwdata[REG_SH_W-1:0];
            restart    <= 1'b1;
          end
          REG_DEST_WIDTH: begin
            dest_width <= pwdata[REG_DW_W-1:0];
            restart    <= 1'b1;
          end
          REG_DEST_HEIGHT: begin
            dest_height <= pwdata[REG_DH_W-1:0];
            restart     <= 1'b1;
          end
          REG_RGBA_MODE: begin
            rgba_mode <= pwdata[0];
            restart   <= 1'b1;
          end
          default: ;  // drop writes past the register list
        endcase
      end
    end
  end

  always_comb begin
    case (reg_idx)
      REG_SRC_WIDTH:   prdata = APB_DATA_W'(src_width);
      REG_SRC_HEIGHT:  prdata = APB_DATA_W'(src_height);
      REG_DEST_WIDTH:  prdata = APB_DATA_W'(dest_width);
      REG_DEST_HEIGHT: prdata = APB_DATA_W'(dest_height);
      REG_RGBA_MODE:   prdata = APB_DATA_W'(rgba_mode);
      default:         prdata = '0;
    endcase
  end

  // effective sizes: zero reads as one, saturate to maxima, never enlarge
  logic [CW-1:0]  sw;
  logic [HW-1:0]  sh, oh;
  logic [OWW-1:0] ow, ow_req;

  always_comb begin
    if (src_width == '0) sw = CW'(1);
    else if (32'(src_width) > MAX_SRC_W) sw = CW'(MAX_SRC_W);
    else sw = CW'(src_width);

    if (src_height == '0) sh = HW'(1);
    else if (32'(src_height) > MAX_SRC_H) sh = HW'(MAX_SRC_H);
    else sh = HW'(src_height);

    if (dest_width == '0) ow_req = OWW'(1);
    else if (32'(dest_width) > MAX_OUT_W) ow_req = OWW'(MAX_OUT_W);
    else ow_req = OWW'(dest_width);
    ow = (32'(ow_req) > 32'(sw)) ? OWW'(sw) : ow_req;

    if (dest_height == '0) oh = HW'(1);
    else if (32'(dest_height) > 32'(sh)) oh = sh;
    else oh = HW'(dest_height);
  end

  abdb_cmd_t      cmd;
  abdb_stat_t     stat;
  logic [CIW-1:0] k;

  abdb_ctrl #(
    .MAX_OUT_W(MAX_OUT_W)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .restart  (restart),
    .stat     (stat),
    .cmd      (cmd),
    .k        (k)
  );

  abdb_datapath #(
    .MAX_SRC_W(MAX_SRC_W),
    .MAX_SRC_H(MAX_SRC_H),
    .MAX_OUT_W(MAX_OUT_W)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .k          (k),
    .restart    (restart),
    .sw         (sw),
    .sh         (sh),
    .ow         (ow),
    .oh         (oh),
    .rgba       (rgba_mode),
    .comp0      (comp0),
    .comp1      (comp1),
    .comp2      (comp2),
    .comp3      (comp3),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out0       (out0),
    .out1       (out1),
    .out2       (out2),
    .out3       (out3),
    .out_col    (out_col),
    .out_row    (out_row),
    .row_last   (row_last),
    .frame_last (frame_last)
  );

endmodule

### rtl/core/abdb_ctrl.sv
// ----------------------------------------------------------------------------
// abdb_ctrl
// Sequencer: per-pixel accumulate cells, output row emission, row advance.
// ----------------------------------------------------------------------------
module abdb_ctrl #(
  parameter int MAX_OUT_W = abdb_pkg::MAX_OUT_W_DEF,
  localparam int CIW = (MAX_OUT_W > 1) ? $clog2(MAX_OUT_W) : 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                restart,
  input  abdb_pkg::abdb_stat_t stat,
  output abdb_pkg::abdb_cmd_t  cmd,
  output logic [CIW-1:0]      k
);
  import abdb_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_RD    = 9'b000000010,
    S_WR    = 9'b000000100,
    S_PIX   = 9'b000001000,
    S_EMRD  = 9'b000010000,
    S_EMLD  = 9'b000100000,
    S_EMDIV = 9'b001000000,
    S_EMOUT = 9'b010000000,
    S_ROW   = 9'b100000000
  } state_t;

  state_t         state, state_next;
  logic [1:0]     part, part_next;
  logic [2:0]     iter, iter_next;
  logic [CIW-1:0] k_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      part  <= '0;
      iter  <= '0;
      k     <= '0;
    end else begin
      state <= state_next;
      part  <= part_next;
      iter  <= iter_next;
      k     <= k_next;
    end
  end

  always_comb begin
    state_next = state;
    part_next  = part;
    iter_next  = iter;
    k_next     = k;
    cmd        = '0;
    cmd.part   = part;
    cmd.iter   = iter;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = !restart;
        if (in_valid && !restart) begin
          cmd.accept = 1'b1;
          part_next  = '0;
          state_next = S_RD;
        end
      end
      S_RD: begin
        if (stat.w_zero) begin
          if (part == PART_LAST) state_next = S_PIX;
          else part_next = part + 2'd1;
        end else begin
          cmd.rd     = 1'b1;
          state_next = S_WR;
        end
      end
      S_WR: begin
        cmd.wr = 1'b1;
        if (part == PART_LAST) begin
          state_next = S_PIX;
        end else begin
          part_next  = part + 2'd1;
          state_next = S_RD;
        end
      end
      S_PIX: begin
        cmd.col_adv = 1'b1;
        if (!stat.row_end) begin
          state_next = S_IDLE;
        end else if (stat.emit) begin
          k_next     = '0;
          state_next = S_EMRD;
        end else begin
          state_next = S_ROW;
        end
      end
      S_EMRD: begin
        cmd.em_rd  = 1'b1;
        state_next = S_EMLD;
      end
      S_EMLD: begin
        cmd.em_ld  = 1'b1;
        iter_next  = '0;
        state_next = S_EMDIV;
      end
      S_EMDIV: begin
        cmd.em_div = 1'b1;
        if (iter == 3'(DIV_STEPS - 1)) state_next = S_EMOUT;
        else iter_next = iter + 3'd1;
      end
      S_EMOUT: begin
        if (stat.out_free) begin
          cmd.em_out = 1'b1;
          if (stat.last_k) begin
            state_next = S_ROW;
          end else begin
            k_next     = k + CIW'(1);
            state_next = S_EMRD;
          end
        end
      end
      S_ROW: begin
        cmd.row_adv = 1'b1;
        state_next  = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

### rtl/core/abdb_datapath.sv
// ----------------------------------------------------------------------------
// abdb_datapath
// Overlap tracking, accumulator memory, rounding divider and output register.
// ----------------------------------------------------------------------------
module abdb_datapath #(
  parameter int MAX_SRC_W = abdb_pkg::MAX_SRC_W_DEF,
  parameter int MAX_SRC_H = abdb_pkg::MAX_SRC_H_DEF,
  parameter int MAX_OUT_W = abdb_pkg::MAX_OUT_W_DEF,
  localparam int CW  = $clog2(MAX_SRC_W + 1),
  localparam int HW  = $clog2(MAX_SRC_H + 1),
  localparam int OWW = $clog2(MAX_OUT_W + 1),
  localparam int CIW = (MAX_OUT_W > 1) ? $clog2(MAX_OUT_W) : 1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  abdb_pkg::abdb_cmd_t           cmd,
  output abdb_pkg::abdb_stat_t          stat,
  input  logic [CIW-1:0]                k,
  input  logic                          restart,
  input  logic [CW-1:0]                 sw,
  input  logic [HW-1:0]                 sh,
  input  logic [OWW-1:0]                ow,
  input  logic [HW-1:0]                 oh,
  input  logic                          rgba,
  input  logic [abdb_pkg::PIX_W-1:0]    comp0,
  input  logic [abdb_pkg::PIX_W-1:0]    comp1,
  input  logic [abdb_pkg::PIX_W-1:0]    comp2,
  input  logic [abdb_pkg::PIX_W-1:0]    comp3,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [abdb_pkg::PIX_W-1:0]    out0,
  output logic [abdb_pkg::PIX_W-1:0]    out1,
  output logic [abdb_pkg::PIX_W-1:0]    out2,
  output logic [abdb_pkg::PIX_W-1:0]    out3,
  output logic [abdb_pkg::OUT_COL_W-1:0] out_col,
  output logic [abdb_pkg::OUT_ROW_W-1:0] out_row,
  output logic                          row_last,
  output logic                          frame_last
);
  import abdb_pkg::*;

  localparam int CLW    = $clog2(MAX_SRC_W * MAX_OUT_W + 1);
  localparam int RLW    = $clog2(MAX_SRC_H * MAX_SRC_H + MAX_SRC_H + 1);
  localparam int DW     = $clog2(MAX_SRC_W * MAX_SRC_H + 1);
  localparam int WW     = OWW + HW;
  localparam int PW     = PIX_W + WW;
  localparam int NW     = ((ACC_W > DW) ? ACC_W : DW) + 2;
  localparam int XW     = NW + DIV_STEPS;
  localparam int BANK_D = 2 ** CIW;
  localparam int MEM_D  = 2 * BANK_D;
  localparam int AW     = CIW + 1;

  // horizontal and vertical overlap tracking
  logic [CW-1:0]  src_col;
  logic [CLW-1:0] col_lo, col_edge, col_hi, col_end;
  logic [CIW-1:0] col_cell;
  logic [HW-1:0]  src_row;
  logic [RLW-1:0] row_lo, row_edge, row_hi, row_end_pos;
  logic [HW-1:0]  row_cell;
  logic [OWW-1:0] cw0, cw1;
  logic [HW-1:0]  rw0, rw1;

  assign col_hi      = col_lo + CLW'(ow);
  assign col_end     = (col_hi < col_edge) ? col_hi : col_edge;
  assign cw0         = OWW'(col_end - col_lo);
  assign cw1         = OWW'(col_hi - col_end);
  assign row_hi      = row_lo + RLW'(oh);
  assign row_end_pos = (row_hi < row_edge) ? row_hi : row_edge;
  assign rw0         = HW'(row_end_pos - row_lo);
  assign rw1         = HW'(row_hi - row_end_pos);

  // latched pixel and its split
  logic [COMP_N-1:0][PIX_W-1:0] px;
  logic [CIW-1:0] ci_q;
  logic           bank0_q;
  logic [OWW-1:0] cw0_q, cw1_q;
  logic [HW-1:0]  rw0_q, rw1_q;

  logic [OWW-1:0] cw_sel;
  logic [HW-1:0]  rw_sel;
  logic [WW-1:0]  weight, w_q;
  logic [AW-1:0]  acc_addr, em_addr, mem_raddr, addr_q;

  assign cw_sel   = cmd.part[0] ? cw1_q : cw0_q;
  assign rw_sel   = cmd.part[1] ? rw1_q : rw0_q;
  assign weight   = cw_sel * rw_sel;
  assign acc_addr = {bank0_q ^ cmd.part[1], ci_q + CIW'(cmd.part[0])};
  assign em_addr  = {row_cell[0], k};
  assign mem_raddr = cmd.em_rd ? em_addr : acc_addr;

  // accumulator memory: {bank, column} -> four sums
  logic [COMP_N-1:0][ACC_W-1:0] mem [MEM_D];
  logic [COMP_N-1:0][ACC_W-1:0] rd_data, wr_data;
  logic [MEM_D-1:0]             vld;
  logic                         rd_vld;
  logic [COMP_N-1:0][PW-1:0]    prod;

  always_comb begin
    for (int c = 0; c < COMP_N; c++) begin
      prod[c]    = px[c] * w_q;
      wr_data[c] = (rd_vld ? rd_data[c] : '0) + ACC_W'(prod[c]);
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[mem_raddr];
    rd_vld  <= vld[mem_raddr];
    if (cmd.wr) mem[addr_q] <= wr_data;
  end

  // rounding divider: q = (2s + den) / (2 den), saturated at 255
  logic [DW-1:0]    den;
  logic [CW+HW-1:0] den_full;
  logic [DW:0]      dd;
  logic [COMP_N-1:0][NW-1:0]    rem;
  logic [COMP_N-1:0][PIX_W-1:0] quo;
  logic [COMP_N-1:0]            sat;
  logic [2:0]                   bit_pos;
  logic [XW-1:0]                dd_shift, dd_top;
  logic [COMP_N-1:0][NW-1:0]    num;

  assign den_full = sw * sh;
  assign dd       = {den, 1'b0};
  assign bit_pos  = 3'(DIV_STEPS - 1) - cmd.iter;
  assign dd_shift = XW'(dd) << bit_pos;
  assign dd_top   = XW'(dd) << DIV_STEPS;

  always_comb begin
    for (int c = 0; c < COMP_N; c++) begin
      num[c] = NW'({(rd_vld ? rd_data[c] : ACC_W'(0)), 1'b0}) + NW'(den);
    end
  end

  always_ff @(posedge clk) begin
    den <= DW'(den_full);
    if (cmd.accept) begin
      px[0]   <= comp0;
      px[1]   <= rgba ? comp1 : '0;
      px[2]   <= rgba ? comp2 : '0;
      px[3]   <= rgba ? comp3 : '0;
      ci_q    <= col_cell;
      bank0_q <= row_cell[0];
      cw0_q   <= cw0;
      cw1_q   <= cw1;
      rw0_q   <= rw0;
      rw1_q   <= rw1;
    end
    if (cmd.rd) begin
      addr_q <= acc_addr;
      w_q    <= weight;
    end
    for (int c = 0; c < COMP_N; c++) begin
      if (cmd.em_ld) begin
        rem[c] <= num[c];
        quo[c] <= '0;
        sat[c] <= XW'(num[c]) >= dd_top;
      end else if (cmd.em_div && !sat[c] && (XW'(rem[c]) >= dd_shift)) begin
        rem[c]          <= rem[c] - NW'(dd_shift);
        quo[c][bit_pos] <= 1'b1;
      end
    end
  end

  // control counters and valid bits
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      src_col  <= '0;
      col_lo   <= '0;
      col_cell <= '0;
      col_edge <= CLW'(sw);
      src_row  <= '0;
      row_lo   <= '0;
      row_cell <= '0;
      row_edge <= RLW'(sh);
      vld      <= '0;
    end else begin
      if (cmd.wr) vld[addr_q] <= 1'b1;
      if (cmd.col_adv) begin
        if (stat.row_end) begin
          src_col  <= '0;
          col_lo   <= '0;
          col_cell <= '0;
          col_edge <= CLW'(sw);
        end else begin
          src_col <= src_col + CW'(1);
          col_lo  <= col_hi;
          if (col_hi >= col_edge) begin
            col_cell <= col_cell + CIW'(1);
            col_edge <= col_edge + CLW'(sw);
          end
        end
      end
      if (cmd.row_adv) begin
        if (src_row + HW'(1) == sh) begin
          // frame done: start over
          src_row  <= '0;
          row_lo   <= '0;
          row_cell <= '0;
          row_edge <= RLW'(sh);
          vld      <= '0;
        end else begin
          src_row <= src_row + HW'(1);
          row_lo  <= row_hi;
          if (stat.emit) begin
            row_cell <= row_cell + HW'(1);
            row_edge <= row_edge + RLW'(sh);
            vld[(row_cell[0] ? BANK_D : 0) +: BANK_D] <= '0;
          end
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.em_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.em_out) begin
      out0       <= sat[0] ? '1 : quo[0];
      out1       <= sat[1] ? '1 : quo[1];
      out2       <= sat[2] ? '1 : quo[2];
      out3       <= sat[3] ? '1 : quo[3];
      out_col    <= OUT_COL_W'(k);
      out_row    <= OUT_ROW_W'(row_cell);
      row_last   <= stat.last_k;
      frame_last <= stat.last_k && ((HW + 1)'(row_cell) + (HW + 1)'(1) >= (HW + 1)'(oh));
    end
  end

  assign stat.w_zero   = (cw_sel == '0) || (rw_sel == '0);
  assign stat.row_end  = (src_col + CW'(1) == sw);
  assign stat.emit     = (row_hi >= row_edge);
  assign stat.last_k   = (k == CIW'(ow - OWW'(1)));
  assign stat.out_free = !out_valid || out_ready;

`ifndef SYNTHESIS
  a_frame_row: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_last |-> row_last)
    else $error("frame_last without row_last");
  a_restart_clear: assert property (@(posedge clk) disable iff (rst)
    restart |=> (vld == '0))
    else $error("valid bits not cleared by restart");
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.em_out |-> (!out_valid || out_ready))
    else $error("output register overwritten");
  a_col_range: assert property (@(posedge clk) disable iff (rst)
    !restart |-> ((OWW + 1)'(col_cell) < (OWW + 1)'(ow)))
    else $error("column cell out of range");
`endif

endmodule
